// File: sv/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg: shared types and constants for the command boundary scanner
// Lexer modes, closer codes, character codes and the stack command bundle.
// ----------------------------------------------------------------------------
package cbs_pkg;

    // default bracket stack depth
    localparam int NEST_DEPTH_DEF = 16;

    // lexer mode, also the encoding seen on the result lex_mode field
    typedef enum logic [1:0] {
        MODE_CODE   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_LINE   = 2'd2,
        MODE_BLOCK  = 2'd3
    } lex_mode_t;

    // closer codes held on the bracket stack
    typedef enum logic [1:0] {
        CL_BRACE = 2'd0,
        CL_BRACK = 2'd1,
        CL_PAREN = 2'd2
    } closer_t;

    // one stack command per processed byte
    typedef struct packed {
        logic    push;
        logic    pop;
        logic    clear;
        closer_t code;
    } stack_op_t;

    // character codes
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_SEMI   = 8'd59;
    localparam logic [7:0] CH_LBRACK = 8'd91;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_RBRACK = 8'd93;
    localparam logic [7:0] CH_LBRACE = 8'd123;
    localparam logic [7:0] CH_RBRACE = 8'd125;

endpackage

// File: sv/cbs_stack.sv
// ----------------------------------------------------------------------------
// cbs_stack: bracket closer stack
// Entry memory with a cached top entry and a registered read of the entry
// just below it, so a pop can follow a push or pop in the next cycle.
// ----------------------------------------------------------------------------
module cbs_stack
    import cbs_pkg::*;
#(
    parameter int NEST_DEPTH = NEST_DEPTH_DEF,
    parameter int CNT_W      = $clog2(NEST_DEPTH + 1),
    parameter int IDX_W      = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  stack_op_t        op,
    output logic [CNT_W-1:0] count,
    output logic [CNT_W-1:0] count_next,
    output closer_t          top
);

    closer_t          mem [NEST_DEPTH];
    logic [CNT_W-1:0] count_reg;
    closer_t          top_reg;
    closer_t          below_reg;
    logic [CNT_W-1:0] below_idx;
    logic             below_ok;
    logic [IDX_W-1:0] rd_addr;

    // next fill count
    always_comb
    begin
        count_next = count_reg;
        if (step)
        begin
            if (op.clear)
                count_next = '0;
            else if (op.push)
                count_next = count_reg + CNT_W'(1);
            else if (op.pop)
                count_next = count_reg - CNT_W'(1);
        end
    end

    // address of the entry that sits below the new top
    always_comb
    begin
        below_ok  = {1'b0, count_next} >= (CNT_W + 1)'(2);
        below_idx = count_next - CNT_W'(2);
        rd_addr   = below_ok ? below_idx[IDX_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // entry memory, write on push, registered read of the entry below top
    always_ff @(posedge clk)
    begin
        if (step && op.push)
            mem[count_reg[IDX_W-1:0]] <= op.code;
        below_reg <= mem[rd_addr];
    end

    // cached top entry
    always_ff @(posedge clk)
    begin
        if (step && op.push)
            top_reg <= op.code;
        else if (step && op.pop)
            top_reg <= below_reg;
    end

    assign count = count_reg;
    assign top   = top_reg;

endmodule

// File: sv/command_boundary_scanner.sv
// ----------------------------------------------------------------------------
// command_boundary_scanner: marks bytes that end a script command
// Lexes a text byte stream, tracks bracket nesting and flags command ends.
// ----------------------------------------------------------------------------
// One text byte goes in per beat and one result beat comes out per byte, at a
// sustained rate of one byte per clock cycle while the result sink holds
// tready high. A byte is captured in an input register and then processed
// into the result register. The lexer mode, the pending flags and the bracket
// stack count update together in that single step; the stack memory keeps
// its top entry in a register and prefetches the entry below it, so pushes
// and pops may follow each other in consecutive cycles. No clearing pass is
// needed after reset. A result beat carries the echoed byte and nest level
// in tdata, the mismatch, overflow and mode in tuser, and tlast marks a byte
// that ends a command (a top-level comma or semicolon).
// ----------------------------------------------------------------------------
module command_boundary_scanner
    import cbs_pkg::*;
#(
    parameter int NEST_DEPTH = NEST_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] echo_byte, [12:8] nest_level
    output logic        m_axis_tlast,   // command_end
    output logic [3:0]  m_axis_tuser    // [0] nest_mismatch, [1] nest_overflow,
                                        // [3:2] lex_mode
);

    localparam int CNT_W = $clog2(NEST_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(NEST_DEPTH);

    // input stage
    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;

    // lexer state
    lex_mode_t  mode_reg, mode_next;
    logic       esc_reg, esc_next;
    logic       slash_reg, slash_next;
    logic       star_reg, star_next;

    // result stage
    logic       out_valid_reg, out_valid_next;
    logic [7:0] echo_reg;
    logic       cmd_end_reg;
    logic       mismatch_reg;
    logic       overflow_reg;
    lex_mode_t  out_mode_reg;
    logic [4:0] level_reg;

    // per-byte decode
    logic       advance;
    logic       code_act;
    logic       cmd_end_c;
    logic       mismatch_c;
    logic       overflow_c;
    stack_op_t  op;
    logic [CNT_W-1:0] stack_count;
    logic [CNT_W-1:0] stack_count_next;
    closer_t    stack_top;
    logic [CNT_W+4:0] level_wide;

    // handshake: move a byte into the result register when it has room
    assign advance        = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready  = !in_valid_reg || advance;
    assign in_valid_next  = (s_axis_tvalid && s_axis_tready) ? 1'b1 :
                            (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    // byte acts as plain code: not escaped and not the second half of // or /*
    assign code_act = !esc_reg && (mode_reg == MODE_CODE) &&
                      !(slash_reg && ((byte_reg == CH_STAR) || (byte_reg == CH_SLASH)));

    // next lexer mode and pending flags
    always_comb
    begin
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        slash_next = slash_reg;
        star_next  = star_reg;
        if (esc_reg)
        begin
            esc_next = 1'b0;
        end
        else if (mode_reg == MODE_BLOCK)
        begin
            star_next = 1'b0;
            if (star_reg && (byte_reg == CH_SLASH))
                mode_next = MODE_CODE;
            else if (byte_reg == CH_BSLASH)
                esc_next = 1'b1;
            else if (byte_reg == CH_STAR)
                star_next = 1'b1;
        end
        else if ((mode_reg == MODE_STRING) || (mode_reg == MODE_LINE))
        begin
            if (byte_reg == CH_BSLASH)
                esc_next = 1'b1;
            else if ((mode_reg == MODE_STRING) && (byte_reg == CH_QUOTE))
                mode_next = MODE_CODE;
            else if ((mode_reg == MODE_LINE) && (byte_reg == CH_LF))
                mode_next = MODE_CODE;
        end
        else
        begin
            slash_next = 1'b0;
            if (slash_reg && (byte_reg == CH_STAR))
            begin
                mode_next = MODE_BLOCK;
                star_next = 1'b0;
            end
            else if (slash_reg && (byte_reg == CH_SLASH))
            begin
                mode_next = MODE_LINE;
            end
            else
            begin
                case (byte_reg)
                    CH_BSLASH: esc_next   = 1'b1;
                    CH_HASH:   mode_next  = MODE_LINE;
                    CH_QUOTE:  mode_next  = MODE_STRING;
                    CH_SLASH:  slash_next = 1'b1;
                    default:   ;
                endcase
            end
        end
    end

    // bracket stack commands and result flags
    always_comb
    begin
        op         = '{push: 1'b0, pop: 1'b0, clear: 1'b0, code: CL_BRACE};
        cmd_end_c  = 1'b0;
        mismatch_c = 1'b0;
        overflow_c = 1'b0;
        if (code_act)
        begin
            case (byte_reg)
                CH_LBRACE: op.code = CL_BRACE;
                CH_LBRACK: op.code = CL_BRACK;
                CH_LPAREN: op.code = CL_PAREN;
                CH_RBRACE: op.code = CL_BRACE;
                CH_RBRACK: op.code = CL_BRACK;
                CH_RPAREN: op.code = CL_PAREN;
                default:   op.code = CL_BRACE;
            endcase
            case (byte_reg)
                CH_LBRACE, CH_LBRACK, CH_LPAREN:
                begin
                    if (stack_count == DEPTH_C)
                        overflow_c = 1'b1;
                    else
                        op.push = 1'b1;
                end
                CH_RBRACE, CH_RBRACK, CH_RPAREN:
                begin
                    if ((stack_count != '0) && (stack_top == op.code))
                        op.pop = 1'b1;
                    else
                    begin
                        op.clear   = 1'b1;
                        mismatch_c = 1'b1;
                    end
                end
                CH_COMMA, CH_SEMI:
                    cmd_end_c = (stack_count == '0);
                default: ;
            endcase
        end
    end

    cbs_stack #(
        .NEST_DEPTH (NEST_DEPTH),
        .CNT_W      (CNT_W)
    ) u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .op         (op),
        .count      (stack_count),
        .count_next (stack_count_next),
        .top        (stack_top)
    );

    // low five bits of the new bracket count
    assign level_wide = {5'b0, stack_count_next};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_CODE;
            esc_reg       <= 1'b0;
            slash_reg     <= 1'b0;
            star_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                mode_reg  <= mode_next;
                esc_reg   <= esc_next;
                slash_reg <= slash_next;
                star_reg  <= star_next;
            end
        end
    end

    // input byte capture
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            byte_reg <= s_axis_tdata;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            echo_reg     <= byte_reg;
            cmd_end_reg  <= cmd_end_c;
            mismatch_reg <= mismatch_c;
            overflow_reg <= overflow_c;
            out_mode_reg <= mode_next;
            level_reg    <= level_wide[4:0];
        end
    end

    // result beat packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, level_reg, echo_reg};
    assign m_axis_tlast  = cmd_end_reg;
    assign m_axis_tuser  = {out_mode_reg, overflow_reg, mismatch_reg};

    // an empty result stage never blocks the input side
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled while result stage empty");

    // the bracket count stays within the stack depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_count <= DEPTH_C)
        else $error("bracket count beyond stack depth");

    // a mismatched closer leaves the stack empty
    a_mismatch_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && mismatch_c |=> stack_count == '0)
        else $error("stack not cleared after mismatch");

    // a command end is only shown at nesting level zero, outside comments and strings
    a_end_top_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> (level_reg == 5'd0) && (out_mode_reg == MODE_CODE))
        else $error("command end inside brackets or non-code mode");

    // an escape and a pending slash never coexist
    a_pending_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(esc_reg && slash_reg))
        else $error("escape and slash pending together");

endmodule

// File: tb/sv/command_boundary_checker.sv
// ----------------------------------------------------------------------------
// command_boundary_checker: scoreboard for the command boundary scanner
// Watches both streams, lexes every accepted text byte with its own copy of
// the scanner state and compares each result beat field by field in order.
// ----------------------------------------------------------------------------
module command_boundary_checker
    import cbs_pkg::*;
#(
    parameter int NEST_DEPTH = NEST_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [7:0] echo_byte, [12:8] nest_level
    input  logic        m_axis_tlast,   // command_end
    input  logic [3:0]  m_axis_tuser,   // [0] nest_mismatch, [1] nest_overflow,
                                        // [3:2] lex_mode
    input  logic        end_of_test,
    output int          outstanding,
    output int          error_count
);

    localparam int MAX_PRINTED = 20;

    typedef struct {
        logic [7:0] echo;
        logic       cmd_end;
        logic       mismatch;
        logic       overflow;
        lex_mode_t  mode;
        logic [4:0] level;
    } scan_result_t;

    // lexer state as the scanner should hold it
    lex_mode_t    lex_state;
    bit           escaped;
    bit           slash_seen;
    bit           star_seen;
    closer_t      closers [NEST_DEPTH];
    int           open_count;

    scan_result_t expected_scans [$];

    // coverage tallies for the closing summary
    int           bytes_seen;
    int           ends_seen;
    int           mismatches_seen;
    int           overflows_seen;
    int           deepest;
    bit           summary_done;

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED)
            $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    // opener: returns 1 when the stack is full and the opener is dropped
    function automatic bit push_closer(input closer_t code);
        if (open_count < NEST_DEPTH)
        begin
            closers[open_count] = code;
            open_count++;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // closer: returns 1 when it does not match the top and the stack is cleared
    function automatic bit pop_closer(input closer_t code);
        if (open_count > 0 && closers[open_count - 1] == code)
        begin
            open_count--;
            return 1'b0;
        end
        open_count = 0;
        return 1'b1;
    endfunction

    // advance the lexer by one byte and build the result it should produce
    function automatic scan_result_t scan_byte(input logic [7:0] b);
        scan_result_t res;
        bit           taken;
        res.echo     = b;
        res.cmd_end  = 1'b0;
        res.mismatch = 1'b0;
        res.overflow = 1'b0;
        taken        = 1'b0;
        if (escaped)
        begin
            escaped = 1'b0;
        end
        else if (lex_state == MODE_BLOCK)
        begin
            if (star_seen && b == CH_SLASH)
            begin
                star_seen = 1'b0;
                lex_state = MODE_CODE;
            end
            else
            begin
                star_seen = 1'b0;
                if (b == CH_BSLASH)
                    escaped = 1'b1;
                else if (b == CH_STAR)
                    star_seen = 1'b1;
            end
        end
        else if (lex_state == MODE_STRING || lex_state == MODE_LINE)
        begin
            if (b == CH_BSLASH)
                escaped = 1'b1;
            else if (lex_state == MODE_STRING && b == CH_QUOTE)
                lex_state = MODE_CODE;
            else if (lex_state == MODE_LINE && b == CH_LF)
                lex_state = MODE_CODE;
        end
        else
        begin
            // a slash left over from the previous byte may open a comment
            if (slash_seen)
            begin
                slash_seen = 1'b0;
                if (b == CH_STAR)
                begin
                    lex_state = MODE_BLOCK;
                    star_seen = 1'b0;
                    taken     = 1'b1;
                end
                else if (b == CH_SLASH)
                begin
                    lex_state = MODE_LINE;
                    taken     = 1'b1;
                end
            end
            if (!taken)
            begin
                case (b)
                    CH_BSLASH: escaped      = 1'b1;
                    CH_LBRACE: res.overflow = push_closer(CL_BRACE);
                    CH_LBRACK: res.overflow = push_closer(CL_BRACK);
                    CH_LPAREN: res.overflow = push_closer(CL_PAREN);
                    CH_RBRACE: res.mismatch = pop_closer(CL_BRACE);
                    CH_RBRACK: res.mismatch = pop_closer(CL_BRACK);
                    CH_RPAREN: res.mismatch = pop_closer(CL_PAREN);
                    CH_HASH:   lex_state    = MODE_LINE;
                    CH_QUOTE:  lex_state    = MODE_STRING;
                    CH_SLASH:  slash_seen   = 1'b1;
                    CH_COMMA,
                    CH_SEMI:   res.cmd_end  = (open_count == 0);
                    default:   ;
                endcase
            end
        end
        res.mode  = lex_state;
        res.level = open_count[4:0];
        return res;
    endfunction

    // compare one result beat against the oldest expectation
    task automatic check_beat();
        scan_result_t exp_res;
        lex_mode_t    got_mode;
        if (expected_scans.size() == 0)
        begin
            report_error($sformatf("result beat 0x%04h with nothing expected", m_axis_tdata));
            return;
        end
        exp_res  = expected_scans.pop_front();
        got_mode = lex_mode_t'(m_axis_tuser[3:2]);
        if (m_axis_tdata[7:0] !== exp_res.echo)
            report_error($sformatf("echo_byte 0x%02h, expected 0x%02h",
                                   m_axis_tdata[7:0], exp_res.echo));
        if (m_axis_tdata[12:8] !== exp_res.level)
            report_error($sformatf("nest_level %0d, expected %0d (byte 0x%02h)",
                                   m_axis_tdata[12:8], exp_res.level, exp_res.echo));
        if (m_axis_tlast !== exp_res.cmd_end)
            report_error($sformatf("command_end %b, expected %b (byte 0x%02h)",
                                   m_axis_tlast, exp_res.cmd_end, exp_res.echo));
        if (m_axis_tuser[0] !== exp_res.mismatch)
            report_error($sformatf("nest_mismatch %b, expected %b (byte 0x%02h)",
                                   m_axis_tuser[0], exp_res.mismatch, exp_res.echo));
        if (m_axis_tuser[1] !== exp_res.overflow)
            report_error($sformatf("nest_overflow %b, expected %b (byte 0x%02h)",
                                   m_axis_tuser[1], exp_res.overflow, exp_res.echo));
        if (m_axis_tuser[3:2] !== exp_res.mode)
            report_error($sformatf("lex_mode %s, expected %s (byte 0x%02h)",
                                   got_mode.name(), exp_res.mode.name(), exp_res.echo));
    endtask

    // predict on accepted text beats, compare on accepted result beats
    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t res;
        if (!rst_n)
        begin
            lex_state       = MODE_CODE;
            escaped         = 1'b0;
            slash_seen      = 1'b0;
            star_seen       = 1'b0;
            open_count      = 0;
            expected_scans.delete();
            outstanding     <= 0;
            error_count     = 0;
            bytes_seen      = 0;
            ends_seen       = 0;
            mismatches_seen = 0;
            overflows_seen  = 0;
            deepest         = 0;
            summary_done    = 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                res = scan_byte(s_axis_tdata);
                expected_scans.insert(expected_scans.size(), res);
                bytes_seen++;
                if (res.cmd_end)
                    ends_seen++;
                if (res.mismatch)
                    mismatches_seen++;
                if (res.overflow)
                    overflows_seen++;
                if (open_count > deepest)
                    deepest = open_count;
            end
            if (m_axis_tvalid && m_axis_tready)
                check_beat();
            outstanding <= expected_scans.size();

            // leftover expectations and run summary
            if (end_of_test && !summary_done)
            begin
                summary_done = 1'b1;
                if (expected_scans.size() != 0)
                    report_error($sformatf("%0d result beats never arrived",
                                           expected_scans.size()));
                $display("lexed %0d bytes: %0d command ends, %0d unmatched closers, %0d dropped openers",
                         bytes_seen, ends_seen, mismatches_seen, overflows_seen);
                $display("deepest bracket nesting reached: %0d of %0d", deepest, NEST_DEPTH);
            end
        end
    end

endmodule

// File: tb/sv/command_boundary_scanner_tb.sv
// ----------------------------------------------------------------------------
// command_boundary_scanner_tb: stream test of the command boundary scanner
// Feeds a short hand-written script and then random script fragments (code,
// brackets, strings, comments, escapes, deep nesting and noise) in bursts,
// with a stalling result sink; the checker judges every result beat.
// ----------------------------------------------------------------------------
module command_boundary_scanner_tb;

    import cbs_pkg::*;

    localparam int DEPTH        = NEST_DEPTH_DEF;
    localparam int RANDOM_BYTES = 1000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 8;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tready = 1'b0;
    logic        end_of_test   = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [3:0]  m_axis_tuser;
    int          outstanding;
    int          error_count;

    logic [7:0]  script [$];
    int          sent_count  = 0;
    int          burst_left  = 0;
    int          cycle_count = 0;
    int          ready_span  = 0;
    int          ready_style = 0;

    command_boundary_scanner #(
        .NEST_DEPTH (DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    command_boundary_checker #(
        .NEST_DEPTH (DEPTH)
    ) i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .end_of_test   (end_of_test),
        .outstanding   (outstanding),
        .error_count   (error_count)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("Test completed with failures");
            $finish;
        end
    end

    // result sink: alternates between always ready, coin flip, mostly stalled
    // and a periodic pattern
    always @(posedge clk)
    begin
        if (ready_span == 0)
        begin
            ready_style <= $urandom_range(0, 3);
            ready_span  <= $urandom_range(20, 120);
        end
        else
        begin
            ready_span <= ready_span - 1;
        end
        case (ready_style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (cycle_count % 5 != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // script text generation
    // ------------------------------------------------------------------

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 3))
            0:       return 8'(8'h61 + $urandom_range(0, 25));
            1:       return 8'(8'h41 + $urandom_range(0, 25));
            2:       return 8'(8'h30 + $urandom_range(0, 9));
            default: return ($urandom_range(0, 1) != 0) ? 8'h20 : 8'h5F;
        endcase
    endfunction

    function automatic logic [7:0] opener_of(input int k);
        case (k)
            0:       return CH_LBRACE;
            1:       return CH_LBRACK;
            default: return CH_LPAREN;
        endcase
    endfunction

    function automatic logic [7:0] closer_of(input int k);
        case (k)
            0:       return CH_RBRACE;
            1:       return CH_RBRACK;
            default: return CH_RPAREN;
        endcase
    endfunction

    // append one byte to the script
    task automatic add_byte(input logic [7:0] b);
        script.insert(script.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_word();
        repeat ($urandom_range(1, 6))
            add_byte(word_char());
    endtask

    // backslash and any byte at all after it
    task automatic add_escape();
        add_byte(CH_BSLASH);
        add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic add_string();
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 8))
        begin
            case ($urandom_range(0, 5))
                0:       add_byte(($urandom_range(0, 1) != 0) ? CH_COMMA : CH_SEMI);
                1:       add_byte(opener_of($urandom_range(0, 2)));
                2:       add_escape();
                default: add_byte(word_char());
            endcase
        end
        add_byte(CH_QUOTE);
    endtask

    task automatic add_line_comment();
        if ($urandom_range(0, 1) != 0)
        begin
            add_byte(CH_HASH);
        end
        else
        begin
            add_byte(CH_SLASH);
            add_byte(CH_SLASH);
        end
        repeat ($urandom_range(0, 10))
        begin
            case ($urandom_range(0, 6))
                0:       add_byte(closer_of($urandom_range(0, 2)));
                1:       add_byte(CH_SEMI);
                2:       add_byte(($urandom_range(0, 1) != 0) ? CH_STAR : CH_SLASH);
                3:       add_escape();
                4:       add_byte(CH_QUOTE);
                default: add_byte(word_char());
            endcase
        end
        add_byte(CH_LF);
    endtask

    // block comment body never holds a bare slash, so only the final one ends it
    task automatic add_block_comment();
        add_byte(CH_SLASH);
        add_byte(CH_STAR);
        repeat ($urandom_range(0, 10))
        begin
            case ($urandom_range(0, 6))
                0:       repeat ($urandom_range(1, 3)) add_byte(CH_STAR);
                1:       add_byte(opener_of($urandom_range(0, 2)));
                2:       add_byte(($urandom_range(0, 1) != 0) ? CH_QUOTE : CH_HASH);
                3:       add_byte(($urandom_range(0, 1) != 0) ? CH_COMMA : CH_LF);
                4:       add_escape();
                default: add_byte(word_char());
            endcase
        end
        repeat ($urandom_range(1, 2))
            add_byte(CH_STAR);
        add_byte(CH_SLASH);
    endtask

    // balanced bracket group with random content
    task automatic add_group(input int level);
        int k;
        k = $urandom_range(0, 2);
        add_byte(opener_of(k));
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(0, 4))
                0:       add_byte(($urandom_range(0, 1) != 0) ? CH_COMMA : CH_SEMI);
                1:       if (level < 5) add_group(level + 1); else add_word();
                2:       add_string();
                default: add_word();
            endcase
        end
        add_byte(closer_of(k));
    endtask

    // nest to the stack depth or past it, then unwind in reverse order
    task automatic add_deep_nest();
        int opened [$];
        int n;
        n = DEPTH + $urandom_range(0, 2);
        repeat (n)
        begin
            opened.insert(opened.size(), int'($urandom_range(0, 2)));
            add_byte(opener_of(opened[$]));
            if ($urandom_range(0, 3) == 0)
                add_byte(word_char());
        end
        while (opened.size() != 0)
        begin
            add_byte(closer_of(opened[$]));
            opened.delete(opened.size() - 1);
        end
        add_byte(CH_SEMI);
    endtask

    task automatic build_fragment();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 38)
        begin
            // one command: words, groups, strings, block comments, then a separator
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 5))
                    0, 1:    add_group(0);
                    2:       add_string();
                    3:       if ($urandom_range(0, 3) == 0) add_block_comment(); else add_word();
                    default: add_word();
                endcase
            end
            add_byte(($urandom_range(0, 1) != 0) ? CH_COMMA : CH_SEMI);
            if ($urandom_range(0, 2) == 0)
                add_byte(CH_LF);
        end
        else if (pick < 48)
            add_string();
        else if (pick < 56)
            add_line_comment();
        else if (pick < 64)
            add_block_comment();
        else if (pick < 70)
            add_deep_nest();
        else if (pick < 76)
        begin
            // stray closer or escaped byte in code
            if ($urandom_range(0, 1) != 0)
                add_byte(closer_of($urandom_range(0, 2)));
            else
                add_escape();
        end
        else if (pick < 86)
        begin
            repeat ($urandom_range(1, 4))
                add_byte(8'($urandom_range(0, 255)));
        end
        else
            add_group(0);
    endtask

    // ------------------------------------------------------------------
    // text stream driver
    // ------------------------------------------------------------------

    // one beat; bursts of random length separated by idle gaps, possibly empty
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 7);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        sent_count++;
    endtask

    task automatic send_script();
        while (script.size() != 0)
            send_byte(script.pop_front());
    endtask

    // hold the text stream until every result beat has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        int directed_count;
        int next_drain;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: byte extremes, top-level ends, matched and unmatched closers,
        // escaped quote in a string, both line comment forms, block comment
        // with repeated stars, dropped slash and an escaped comma in code
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text(";({,}),)[}");
        add_text("\"\\\"\"#\n//\n/***//a\\,");
        directed_count = script.size();
        send_script();
        drain_results();

        // random script fragments, with a full drain every few hundred bytes
        next_drain = directed_count + $urandom_range(250, 400);
        while (sent_count - directed_count < RANDOM_BYTES)
        begin
            build_fragment();
            send_script();
            if (sent_count >= next_drain)
            begin
                drain_results();
                next_drain = sent_count + $urandom_range(250, 400);
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
sv/cbs_pkg.sv
sv/cbs_stack.sv
sv/command_boundary_scanner.sv
tb/sv/command_boundary_checker.sv
tb/sv/command_boundary_scanner_tb.sv
